// ===== hw/rtl/ffha_pkg.sv =====
// shared types and codes for the first-fit heap allocator
package ffha_pkg;

  typedef enum logic [0:0] {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_ZERO   = 2'd1,
    STAT_NOMEM  = 2'd2,
    STAT_DOUBLE = 2'd3
  } status_t;

  localparam int LIMIT_W = 13;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_A_SIZE,
    ST_A_WALK,
    ST_A_HDR,
    ST_A_LINK,
    ST_A_NEW0,
    ST_A_NEW1,
    ST_A_SPLIT0,
    ST_A_SPLIT1,
    ST_A_SPLIT2,
    ST_A_FIN,
    ST_R_HDR,
    ST_R_NBR,
    ST_R_LEFT,
    ST_R_LHDR,
    ST_R_MARK,
    ST_R_RRD,
    ST_R_RHDR,
    ST_R_MRG0,
    ST_R_MRG1,
    ST_R_LCHK,
    ST_L_MRG0,
    ST_L_MRG1,
    ST_RM0,
    ST_RM1,
    ST_RM2,
    ST_RM3,
    ST_RM4,
    ST_RM5,
    ST_AP0,
    ST_AP1,
    ST_AP2,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module ffha_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// First-fit heap allocator. Block headers, left-neighbor links and free-list links all
// live in one heap memory with one read and one write port and a registered read, and a
// sequencer walks that memory one access per cycle while a transaction is in progress.
// An allocate converts the size, then walks the free list; a hit then unlinks the block,
// splits it if large enough and appends the remainder, while a miss grows the break. A
// release checks the block and its neighbors, marks it free and may merge it with one or
// both neighbors before appending it to the free list. The free-list walk, two memory
// reads per step (header and next link), sets the allocate time. The result sits in an
// output register, so a new transaction is accepted while it waits.
module first_fit_heap_allocator #(
  parameter int HEAP_WORDS = 4096,
  parameter int WORD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [14:0] request_bytes,
  input  logic [11:0] release_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] data_word,
  output logic [1:0]  status,
  input  logic        cfg_write_en,
  input  logic [12:0] cfg_write_data
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int DW = AW + 1;
  localparam int CW = (AW + 2 > 17) ? AW + 2 : 17;
  localparam int RS = 18;
  localparam int RM = (2 ** RS + WORD_BYTES - 1) / WORD_BYTES;
  localparam int PW = 15 + RS + 1;
  localparam logic [CW-1:0] NIL = CW'(HEAP_WORDS);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);
  localparam logic [CW-1:0] THREE = CW'(3);
  localparam logic [CW-1:0] SPLIT_MIN = CW'(4);

  ffha_pkg::state_t state, state_next, ret;

  logic [ffha_pkg::LIMIT_W-1:0] limit;
  logic [CW-1:0] brk, head, tail, rmost;
  logic [CW-1:0] blk, blk_size, cur, req_w, lft, lft_size, rgt, rgt_size;
  logic [CW-1:0] lnk_p, lnk_n, rm_x, ap_x, res_data;
  logic [AW:0]   cnt;
  logic [PW-1:0] prod;
  logic          hb_free, lft_free, rd_oor;
  logic [1:0]    res_status;

  logic          mem_we;
  logic [CW-1:0] mem_wa, mem_wd, mem_ra;
  logic [DW-1:0] ram_q;
  logic [CW-1:0] rv, rv_size, hdr_end, rel_b, split_b, lim, quo;
  logic          fit, exhausted, rel_bad;

  assign rv       = rd_oor ? '0 : CW'(ram_q);
  assign rv_size  = rv >> 1;
  assign hdr_end  = blk + TWO + rv_size;
  assign rel_b    = CW'(release_word) - TWO;
  assign rel_bad  = (CW'(release_word) < TWO) || (rel_b >= brk);
  assign split_b  = blk + TWO + req_w;
  assign fit      = (rv_size == req_w) || (rv_size >= req_w + SPLIT_MIN);
  assign lim      = (CW'(limit) < NIL) ? CW'(limit) : NIL;
  assign exhausted = (brk > lim) || (req_w + TWO > lim - brk);
  assign quo      = CW'(prod >> RS) + ONE;
  assign in_ready = (state == ffha_pkg::ST_IDLE);

  ffha_ram #(.WIDTH(DW), .DEPTH(HEAP_WORDS)) u_heap (
    .clk   (clk),
    .we    (mem_we && (mem_wa < NIL)),
    .waddr (mem_wa[AW-1:0]),
    .wdata (mem_wd[DW-1:0]),
    .raddr (mem_ra[AW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      ffha_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == ffha_pkg::CMD_ALLOC) begin
            state_next = (request_bytes == '0) ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_SIZE;
          end else begin
            state_next = rel_bad ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_HDR;
          end
        end
      end
      ffha_pkg::ST_A_SIZE: state_next = ffha_pkg::ST_A_WALK;
      ffha_pkg::ST_A_WALK: begin
        if (cur >= NIL || cnt == (AW+1)'(HEAP_WORDS)) begin
          state_next = ffha_pkg::ST_A_NEW0;
        end else begin
          state_next = ffha_pkg::ST_A_HDR;
        end
      end
      ffha_pkg::ST_A_HDR:  state_next = fit ? ffha_pkg::ST_RM0 : ffha_pkg::ST_A_LINK;
      ffha_pkg::ST_A_LINK: state_next = ffha_pkg::ST_A_WALK;
      ffha_pkg::ST_A_NEW0: state_next = exhausted ? ffha_pkg::ST_DONE : ffha_pkg::ST_A_NEW1;
      ffha_pkg::ST_A_NEW1: state_next = ffha_pkg::ST_DONE;
      ffha_pkg::ST_A_SPLIT0: begin
        state_next = (blk_size > req_w) ? ffha_pkg::ST_A_SPLIT1 : ffha_pkg::ST_A_FIN;
      end
      ffha_pkg::ST_A_SPLIT1: state_next = ffha_pkg::ST_A_SPLIT2;
      ffha_pkg::ST_A_SPLIT2: state_next = ffha_pkg::ST_AP0;
      ffha_pkg::ST_A_FIN:    state_next = ffha_pkg::ST_DONE;
      ffha_pkg::ST_R_HDR: begin
        if (hdr_end > brk) begin
          state_next = ffha_pkg::ST_DONE;
        end else if (blk == rmost) begin
          state_next = (hdr_end != brk) ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_LEFT;
        end else begin
          state_next = (hdr_end >= brk) ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_NBR;
        end
      end
      ffha_pkg::ST_R_NBR: state_next = (rv != blk) ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_LEFT;
      ffha_pkg::ST_R_LEFT: begin
        if (rv != NIL) begin
          state_next = (rv >= blk) ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_LHDR;
        end else begin
          state_next = hb_free ? ffha_pkg::ST_DONE : ffha_pkg::ST_R_MARK;
        end
      end
      ffha_pkg::ST_R_LHDR: begin
        if (lft + TWO + rv_size != blk || hb_free) begin
          state_next = ffha_pkg::ST_DONE;
        end else begin
          state_next = ffha_pkg::ST_R_MARK;
        end
      end
      ffha_pkg::ST_R_MARK: begin
        state_next = (blk != rmost) ? ffha_pkg::ST_R_RRD : ffha_pkg::ST_R_LCHK;
      end
      ffha_pkg::ST_R_RRD:  state_next = ffha_pkg::ST_R_RHDR;
      ffha_pkg::ST_R_RHDR: state_next = rv[0] ? ffha_pkg::ST_RM0 : ffha_pkg::ST_R_LCHK;
      ffha_pkg::ST_R_MRG0: state_next = ffha_pkg::ST_R_MRG1;
      ffha_pkg::ST_R_MRG1: state_next = ffha_pkg::ST_R_LCHK;
      ffha_pkg::ST_R_LCHK: begin
        state_next = (lft != NIL && lft_free) ? ffha_pkg::ST_RM0 : ffha_pkg::ST_AP0;
      end
      ffha_pkg::ST_L_MRG0: state_next = ffha_pkg::ST_L_MRG1;
      ffha_pkg::ST_L_MRG1: state_next = ffha_pkg::ST_AP0;
      ffha_pkg::ST_RM0:    state_next = ffha_pkg::ST_RM1;
      ffha_pkg::ST_RM1:    state_next = ffha_pkg::ST_RM2;
      ffha_pkg::ST_RM2:    state_next = ffha_pkg::ST_RM3;
      ffha_pkg::ST_RM3:    state_next = ffha_pkg::ST_RM4;
      ffha_pkg::ST_RM4:    state_next = ffha_pkg::ST_RM5;
      ffha_pkg::ST_RM5:    state_next = ret;
      ffha_pkg::ST_AP0:    state_next = ffha_pkg::ST_AP1;
      ffha_pkg::ST_AP1:    state_next = ffha_pkg::ST_AP2;
      ffha_pkg::ST_AP2:    state_next = ret;
      ffha_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ffha_pkg::ST_IDLE;
        end
      end
      default: state_next = ffha_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = '0;
    case (state)
      ffha_pkg::ST_IDLE:   mem_ra = rel_b;
      ffha_pkg::ST_A_WALK: mem_ra = cur;
      ffha_pkg::ST_A_HDR:  mem_ra = cur + THREE;
      ffha_pkg::ST_A_NEW0: begin
        mem_we = !exhausted;
        mem_wa = brk;
        mem_wd = req_w << 1;
      end
      ffha_pkg::ST_A_NEW1: begin
        mem_we = 1'b1;
        mem_wa = blk + ONE;
        mem_wd = rmost;
      end
      ffha_pkg::ST_A_SPLIT0: begin
        mem_we = blk_size > req_w;
        mem_wa = split_b;
        mem_wd = ((blk_size - TWO - req_w) << 1) | ONE;
      end
      ffha_pkg::ST_A_SPLIT1: begin
        mem_we = blk != rmost;
        mem_wa = blk + TWO + blk_size + ONE;
        mem_wd = split_b;
      end
      ffha_pkg::ST_A_SPLIT2: begin
        mem_we = 1'b1;
        mem_wa = split_b + ONE;
        mem_wd = blk;
      end
      ffha_pkg::ST_A_FIN: begin
        mem_we = 1'b1;
        mem_wa = blk;
        mem_wd = req_w << 1;
      end
      ffha_pkg::ST_R_HDR:  mem_ra = (blk == rmost) ? blk + ONE : hdr_end + ONE;
      ffha_pkg::ST_R_NBR:  mem_ra = blk + ONE;
      ffha_pkg::ST_R_LEFT: mem_ra = rv;
      ffha_pkg::ST_R_MARK: begin
        mem_we = 1'b1;
        mem_wa = blk;
        mem_wd = (blk_size << 1) | ONE;
      end
      ffha_pkg::ST_R_RRD:  mem_ra = rgt;
      ffha_pkg::ST_R_MRG0: begin
        mem_we = rgt != rmost;
        mem_wa = rgt + TWO + rgt_size + ONE;
        mem_wd = blk;
      end
      ffha_pkg::ST_R_MRG1: begin
        mem_we = 1'b1;
        mem_wa = blk;
        mem_wd = ((blk_size + rgt_size + TWO) << 1) | ONE;
      end
      ffha_pkg::ST_L_MRG0: begin
        mem_we = blk != rmost;
        mem_wa = blk + TWO + blk_size + ONE;
        mem_wd = lft;
      end
      ffha_pkg::ST_L_MRG1: begin
        mem_we = 1'b1;
        mem_wa = lft;
        mem_wd = ((lft_size + blk_size + TWO) << 1) | ONE;
      end
      ffha_pkg::ST_RM0: mem_ra = rm_x + TWO;
      ffha_pkg::ST_RM1: mem_ra = rm_x + THREE;
      ffha_pkg::ST_RM2: begin
        mem_we = lnk_p != NIL;
        mem_wa = lnk_p + THREE;
        mem_wd = rv;
      end
      ffha_pkg::ST_RM3: begin
        mem_we = lnk_n != NIL;
        mem_wa = lnk_n + TWO;
        mem_wd = lnk_p;
      end
      ffha_pkg::ST_RM4: begin
        mem_we = 1'b1;
        mem_wa = rm_x + TWO;
        mem_wd = NIL;
      end
      ffha_pkg::ST_RM5: begin
        mem_we = 1'b1;
        mem_wa = rm_x + THREE;
        mem_wd = NIL;
      end
      ffha_pkg::ST_AP0: begin
        mem_we = 1'b1;
        mem_wa = ap_x + TWO;
        mem_wd = (tail == NIL || head == NIL) ? NIL : tail;
      end
      ffha_pkg::ST_AP1: begin
        mem_we = 1'b1;
        mem_wa = ap_x + THREE;
        mem_wd = NIL;
      end
      ffha_pkg::ST_AP2: begin
        mem_we = head != NIL;
        mem_wa = tail + THREE;
        mem_wd = ap_x;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_oor <= !(mem_ra < NIL);
    if (rst) begin
      state     <= ffha_pkg::ST_IDLE;
      ret       <= ffha_pkg::ST_IDLE;
      limit     <= ffha_pkg::LIMIT_RESET;
      brk       <= '0;
      head      <= NIL;
      tail      <= NIL;
      rmost     <= NIL;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        limit <= cfg_write_data;
      end
      if (out_valid && out_ready && state != ffha_pkg::ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ffha_pkg::ST_IDLE: begin
          if (in_valid) begin
            res_data   <= '0;
            blk        <= rel_b;
            prod       <= PW'((request_bytes - 15'd1) * RM);
            if (command == ffha_pkg::CMD_ALLOC && request_bytes == '0) begin
              res_status <= ffha_pkg::STAT_ZERO;
            end else if (command != ffha_pkg::CMD_ALLOC && rel_bad) begin
              res_status <= ffha_pkg::STAT_NOMEM;
            end else begin
              res_status <= ffha_pkg::STAT_OK;
            end
          end
        end
        ffha_pkg::ST_A_SIZE: begin
          req_w <= (quo < TWO) ? TWO : quo;
          cur   <= head;
          cnt   <= '0;
        end
        ffha_pkg::ST_A_HDR: begin
          if (fit) begin
            blk      <= cur;
            blk_size <= rv_size;
            rm_x     <= cur;
            ret      <= ffha_pkg::ST_A_SPLIT0;
          end
        end
        ffha_pkg::ST_A_LINK: begin
          cur <= rv;
          cnt <= cnt + 1'b1;
        end
        ffha_pkg::ST_A_NEW0: begin
          if (exhausted) begin
            res_status <= ffha_pkg::STAT_NOMEM;
          end else begin
            blk <= brk;
            brk <= brk + req_w + TWO;
          end
        end
        ffha_pkg::ST_A_NEW1: begin
          rmost    <= blk;
          res_data <= blk + TWO;
        end
        ffha_pkg::ST_A_SPLIT1: begin
          if (blk == rmost) begin
            rmost <= split_b;
          end
        end
        ffha_pkg::ST_A_SPLIT2: begin
          ap_x <= split_b;
          ret  <= ffha_pkg::ST_A_FIN;
        end
        ffha_pkg::ST_A_FIN: res_data <= blk + TWO;
        ffha_pkg::ST_R_HDR: begin
          blk_size <= rv_size;
          hb_free  <= rv[0];
          rgt      <= hdr_end;
          if (hdr_end > brk || (blk == rmost && hdr_end != brk) ||
              (blk != rmost && hdr_end >= brk)) begin
            res_status <= ffha_pkg::STAT_NOMEM;
          end
        end
        ffha_pkg::ST_R_NBR: begin
          if (rv != blk) begin
            res_status <= ffha_pkg::STAT_NOMEM;
          end
        end
        ffha_pkg::ST_R_LEFT: begin
          lft      <= rv;
          lft_free <= 1'b0;
          if (rv != NIL) begin
            if (rv >= blk) begin
              res_status <= ffha_pkg::STAT_NOMEM;
            end
          end else if (hb_free) begin
            res_status <= ffha_pkg::STAT_DOUBLE;
          end
        end
        ffha_pkg::ST_R_LHDR: begin
          lft_size <= rv_size;
          lft_free <= rv[0];
          if (lft + TWO + rv_size != blk) begin
            res_status <= ffha_pkg::STAT_NOMEM;
          end else if (hb_free) begin
            res_status <= ffha_pkg::STAT_DOUBLE;
          end
        end
        ffha_pkg::ST_R_RHDR: begin
          rgt_size <= rv_size;
          if (rv[0]) begin
            rm_x <= rgt;
            ret  <= ffha_pkg::ST_R_MRG0;
          end
        end
        ffha_pkg::ST_R_MRG0: begin
          if (rgt == rmost) begin
            rmost <= blk;
          end
        end
        ffha_pkg::ST_R_MRG1: blk_size <= blk_size + rgt_size + TWO;
        ffha_pkg::ST_R_LCHK: begin
          if (lft != NIL && lft_free) begin
            rm_x <= lft;
            ret  <= ffha_pkg::ST_L_MRG0;
          end else begin
            ap_x <= blk;
            ret  <= ffha_pkg::ST_DONE;
          end
        end
        ffha_pkg::ST_L_MRG0: begin
          if (blk == rmost) begin
            rmost <= lft;
          end
        end
        ffha_pkg::ST_L_MRG1: begin
          ap_x <= lft;
          ret  <= ffha_pkg::ST_DONE;
        end
        ffha_pkg::ST_RM1: lnk_p <= rv;
        ffha_pkg::ST_RM2: begin
          lnk_n <= rv;
          if (lnk_p == NIL) begin
            head <= rv;
          end
        end
        ffha_pkg::ST_RM3: begin
          if (lnk_n == NIL) begin
            tail <= lnk_p;
          end
        end
        ffha_pkg::ST_AP2: begin
          if (head == NIL) begin
            head <= ap_x;
          end
          tail <= ap_x;
        end
        ffha_pkg::ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            data_word <= res_data[11:0];
            status    <= res_status;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_err_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ffha_pkg::STAT_OK || data_word == '0))
    else $error("error result carries a data word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_break_bound: assert property (@(posedge clk) disable iff (rst)
    brk <= NIL)
    else $error("heap break past end of heap");

  a_rmost_below_break: assert property (@(posedge clk) disable iff (rst)
    (rmost == NIL) || (rmost < brk))
    else $error("rightmost block not below break");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (state == ffha_pkg::ST_DONE && out_valid && !out_ready) |=> state == ffha_pkg::ST_DONE)
    else $error("result dropped while output stalled");
`endif

endmodule
